/* src/sgs_pkg.sv */
// Shared types and constants for the RGB-to-gray Sobel edge stream.
package sgs_pkg;

  localparam logic [7:0] GRAY_W_BLUE  = 8'd18;
  localparam logic [7:0] GRAY_W_GREEN = 8'd183;
  localparam logic [7:0] GRAY_W_RED   = 8'd54;

  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [0:0]  REG_IMAGE_WIDTH = 1'b0;

  typedef struct packed {
    logic [7:0]  edge_magnitude;
    logic [11:0] center_row;
    logic [10:0] center_col;
  } res_t;

endpackage

/* src/sgs_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
module sgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/sgs_fifo.sv */
// Small register FIFO used between the front end, the back end and the result port.
module sgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/sgs_front.sv */
// Front end: gray conversion and raster position tracking for each accepted pixel.
module sgs_front import sgs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [7:0]                           blue,
  input  logic [7:0]                           green,
  input  logic [7:0]                           red,
  input  logic                                 frame_start,
  input  logic [11:0]                          image_width,
  output logic [8+12+$clog2(MAX_WIDTH)-1:0]    item
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] col_r, col_start, col_cur, col_nxt;
  logic [11:0]   row_r, row_start, row_cur, row_nxt;
  logic [CW:0]   eff_w, col_inc;
  logic          wrap_in, wrap_out;
  logic [15:0]   prod_b, prod_g, prod_r;
  logic [7:0]    gray;

  always_comb begin
    if (image_width < 12'd3) begin
      eff_w = (CW+1)'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(image_width);
    end
  end

  always_comb begin
    col_start = frame_start ? '0 : col_r;
    row_start = frame_start ? '0 : row_r;
    wrap_in   = ({1'b0, col_start} >= eff_w);
    col_cur   = wrap_in ? '0 : col_start;
    row_cur   = wrap_in ? row_start + 12'd1 : row_start;
    col_inc   = {1'b0, col_cur} + (CW+1)'(1);
    wrap_out  = (col_inc >= eff_w);
    col_nxt   = wrap_out ? '0 : col_inc[CW-1:0];
    row_nxt   = wrap_out ? row_cur + 12'd1 : row_cur;
  end

  assign prod_b = blue * GRAY_W_BLUE;
  assign prod_g = green * GRAY_W_GREEN;
  assign prod_r = red * GRAY_W_RED;
  // each term stays below 256 and the sum peaks at 252
  assign gray   = prod_b[15:8] + prod_g[15:8] + prod_r[15:8];

  assign item = {gray, row_cur, col_cur};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* src/sgs_back.sv */
// Back end: line stores, 3x3 window and Sobel magnitude for each queued pixel.
module sgs_back import sgs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [8+12+$clog2(MAX_WIDTH)-1:0] q_item,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output res_t                              res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int IW = 8 + 12 + CW;

  logic [IW-1:0] s1_item_r;
  logic          s1_valid_r;
  logic [7:0]    s1_gray;
  logic [11:0]   s1_row;
  logic [CW-1:0] s1_col, q_col;
  logic [15:0]   ram_rdata;
  logic          byp_r;
  logic [7:0]    byp_up_r, byp_mid_r;
  logic [7:0]    tr, mr, br;
  logic [7:0]    win_r [6];
  logic          emit, s1_done;
  logic [9:0]    sum_r, sum_l, sum_t, sum_b, gx, gy;
  logic [10:0]   mag;
  logic [11:0]   crow;
  logic [CW-1:0] ccol;
  logic [7:0]    mag_sat;

  assign {s1_gray, s1_row, s1_col} = s1_item_r;
  assign q_col = q_item[CW-1:0];

  assign emit    = (s1_row != '0) && (s1_col != '0);
  assign s1_done = s1_valid_r && (!emit || !res_full);
  assign q_pop   = !q_empty && (!s1_valid_r || s1_done);

  sgs_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_done),
    .waddr(s1_col),
    .wdata({mr, s1_gray}),
    .re   (q_pop),
    .raddr(q_col),
    .rdata(ram_rdata)
  );

  // same-address write in the read cycle: take the new data
  assign tr = byp_r ? byp_up_r : ram_rdata[15:8];
  assign mr = byp_r ? byp_mid_r : ram_rdata[7:0];
  assign br = s1_gray;

  always_comb begin
    sum_r = 10'(tr) + {1'b0, mr, 1'b0} + 10'(br);
    sum_l = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    sum_t = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(tr);
    sum_b = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(br);
    gx    = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
    gy    = (sum_t >= sum_b) ? sum_t - sum_b : sum_b - sum_t;
    mag   = 11'(gx) + 11'(gy);
    mag_sat = (mag > 11'd255) ? 8'd255 : mag[7:0];
    crow  = s1_row - 12'd1;
    ccol  = s1_col - CW'(1);
  end

  assign res_push           = s1_done && emit;
  assign res.edge_magnitude = ((crow != '0) && (ccol != '0)) ? mag_sat : 8'd0;
  assign res.center_row     = crow;
  assign res.center_col     = 11'(ccol);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      byp_up_r  <= mr;
      byp_mid_r <= s1_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_done && (q_col == s1_col);
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_done) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= tr;
        win_r[4] <= mr;
        win_r[5] <= br;
      end
    end
  end

`ifndef SYNTH
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_valid_r)
    else $error("popped word not held in stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_done |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled word changed");

  a_top_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (res.center_row == '0) |-> res.edge_magnitude == '0)
    else $error("nonzero magnitude on top row");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && s1_done && (q_col == s1_col) |=> byp_r)
    else $error("same-address bypass missed");
`endif

endmodule

/* src/rgb_gray_sobel_edge_stream.sv */
// Streaming BGR-to-gray 3x3 Sobel edge detector with APB width register.
// Takes one pixel per clock and delivers one word per clock while the result
// side is not stalled; the rate is set by the line-store RAM, which does one
// read and one write per cycle. An accepted pixel goes through the input
// queue and stage register into the result FIFO. Pixels are queued after gray
// conversion, so the input keeps flowing for a few words while the result
// side is stalled. Results lag by one row and one column; centers on the
// top row or left column read 0, and last-row and last-column centers are
// never produced. image_width (byte address 0) is clamped to 3..MAX_WIDTH
// and must be written only while the block is idle.
module rgb_gray_sobel_edge_stream import sgs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        in_frame_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_edge_magnitude,
  output logic [11:0] out_center_row,
  output logic [10:0] out_center_col,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = 8 + 12 + $clog2(MAX_WIDTH);
  localparam int QDEPTH = 4;
  localparam int RDEPTH = 2;

  logic [11:0]   image_width_r;
  logic          accept;
  logic [IW-1:0] f_item, q_item;
  logic          q_empty, q_pop;
  logic          res_full, res_push;
  res_t          res, res_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_IMAGE_WIDTH) ? {20'd0, image_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_IMAGE_WIDTH)) begin
      image_width_r <= pwdata[11:0];
    end
  end

  assign accept = push && !full;

  sgs_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .blue       (in_blue),
    .green      (in_green),
    .red        (in_red),
    .frame_start(in_frame_start),
    .image_width(image_width_r),
    .item       (f_item)
  );

  sgs_fifo #(
    .WIDTH(IW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(f_item),
    .full (full),
    .pop  (q_pop),
    .rdata(q_item),
    .empty(q_empty)
  );

  sgs_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  sgs_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RDEPTH)
  ) u_results (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign out_edge_magnitude = res_out.edge_magnitude;
  assign out_center_row     = res_out.center_row;
  assign out_center_col     = res_out.center_col;

endmodule
